### rtl/uvc_sfa_pkg.sv
// ----------------------------------------------------------------------------
// Stereo frame assembler package
// Result codes, header byte positions, frame limits and shared payload types.
// ----------------------------------------------------------------------------
package uvc_sfa_pkg;

   // Frame and packet limits
   localparam int unsigned FRAME_PIXELS     = 153600;
   localparam int unsigned MAX_PACKET_BYTES = 65535;

   // Field widths
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned INDEX_W = 18;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned POS_W   = 16;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_PIXEL_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FRAME_GOOD  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FRAME_DROP  = 2'd2;

   // Header byte positions within a packet
   localparam logic [POS_W-1:0] POS_HEADER_LENGTH = 16'd0;
   localparam logic [POS_W-1:0] POS_HEADER_FLAGS  = 16'd1;
   localparam logic [POS_W-1:0] POS_TIME_FIRST    = 16'd2;
   localparam logic [POS_W-1:0] POS_TIME_LAST     = 16'd5;

   // End-of-frame bit in the header flags
   localparam int unsigned EOF_FLAG_BIT = 1;

   typedef struct packed {
      logic [KIND_W-1:0]  result_kind;
      logic [INDEX_W-1:0] pixel_index;
      logic [BYTE_W-1:0]  left_pixel;
      logic [BYTE_W-1:0]  right_pixel;
      logic [TIME_W-1:0]  frame_time;
   } result_type;

   // Up to two results produced by one payload byte, oldest in slot_a
   typedef struct packed {
      logic [1:0] count;
      result_type slot_a;
      result_type slot_b;
   } push_type;

endpackage

### rtl/uvc_sfa_if.sv
// ----------------------------------------------------------------------------
// Stereo frame assembler channels
// Valid/ready channels for payload bytes in and assembled results out.
// ----------------------------------------------------------------------------
interface uvc_sfa_req_if;
   logic                             valid;
   logic                             ready;
   logic [uvc_sfa_pkg::BYTE_W-1:0]   payload_byte;
   logic                             first_of_packet;
   logic                             last_of_packet;

   modport source (output valid, output payload_byte, output first_of_packet,
                   output last_of_packet, input ready);
   modport sink   (input valid, input payload_byte, input first_of_packet,
                   input last_of_packet, output ready);
endinterface

interface uvc_sfa_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [uvc_sfa_pkg::KIND_W-1:0]   result_kind;
   logic [uvc_sfa_pkg::INDEX_W-1:0]  pixel_index;
   logic [uvc_sfa_pkg::BYTE_W-1:0]   left_pixel;
   logic [uvc_sfa_pkg::BYTE_W-1:0]   right_pixel;
   logic [uvc_sfa_pkg::TIME_W-1:0]   frame_time;

   modport source (output valid, output result_kind, output pixel_index,
                   output left_pixel, output right_pixel, output frame_time,
                   input ready);
   modport sink   (input valid, input result_kind, input pixel_index,
                   input left_pixel, input right_pixel, input frame_time,
                   output ready);
endinterface

### rtl/uvc_sfa_parser.sv
// ----------------------------------------------------------------------------
// Stereo frame assembler packet parser
// Registers each payload byte, walks the packet header, pairs pixel bytes and
// produces pixel writes and end-of-frame results.
// ----------------------------------------------------------------------------
module uvc_sfa_parser (
   input  logic                     clock,
   input  logic                     reset,
   uvc_sfa_req_if.sink              req_if,
   input  logic                     room,
   output uvc_sfa_pkg::push_type    push
);

   localparam int unsigned BW = uvc_sfa_pkg::BYTE_W;
   localparam int unsigned TW = uvc_sfa_pkg::TIME_W;
   localparam int unsigned IW = uvc_sfa_pkg::INDEX_W;
   localparam int unsigned PW = uvc_sfa_pkg::POS_W;

   logic          in_valid_ff, in_valid_in;
   logic [BW-1:0] in_byte_ff;
   logic          in_first_ff;
   logic          in_last_ff;

   logic [PW-1:0] byte_position_ff, byte_position_in;
   logic [BW-1:0] header_length_ff, header_length_in;
   logic [BW-1:0] header_flags_ff, header_flags_in;
   logic [TW-1:0] packet_time_ff, packet_time_in;
   logic [TW-1:0] frame_time_ff, frame_time_in;
   logic [IW-1:0] pixel_count_ff, pixel_count_in;
   logic [BW-1:0] held_left_ff, held_left_in;
   logic          holding_left_ff, holding_left_in;

   logic [PW-1:0] pos;
   logic [1:0]    time_lane;
   logic          write_valid;
   logic          frame_valid;
   uvc_sfa_pkg::result_type write_res;
   uvc_sfa_pkg::result_type frame_res;

   assign req_if.ready = room;
   assign in_valid_in  = req_if.valid && req_if.ready;
   assign time_lane    = pos[1:0] - 2'd2;

   always_comb begin
      pos              = in_first_ff ? '0 : byte_position_ff;
      byte_position_in = byte_position_ff;
      header_length_in = header_length_ff;
      header_flags_in  = header_flags_ff;
      packet_time_in   = packet_time_ff;
      frame_time_in    = frame_time_ff;
      pixel_count_in   = pixel_count_ff;
      held_left_in     = held_left_ff;
      holding_left_in  = holding_left_ff;
      write_valid      = 1'b0;
      frame_valid      = 1'b0;
      write_res        = '0;
      frame_res        = '0;

      if (in_valid_ff) begin
         if (pos < PW'(uvc_sfa_pkg::MAX_PACKET_BYTES)) begin
            priority if (pos == uvc_sfa_pkg::POS_HEADER_LENGTH) begin
               header_length_in = in_byte_ff;
               header_flags_in  = '0;
               packet_time_in   = '0;
               holding_left_in  = 1'b0;
               held_left_in     = '0;
            end else if (pos == uvc_sfa_pkg::POS_HEADER_FLAGS) begin
               header_flags_in = in_byte_ff;
            end else if (pos >= uvc_sfa_pkg::POS_TIME_FIRST &&
                         pos <= uvc_sfa_pkg::POS_TIME_LAST) begin
               packet_time_in = packet_time_ff |
                                (TW'(in_byte_ff) << {time_lane, 3'b000});
               if (pos == uvc_sfa_pkg::POS_TIME_LAST && frame_time_ff == '0) begin
                  frame_time_in = packet_time_in;
               end
            end else begin
               header_flags_in = header_flags_ff;
            end

            // Pixel bytes start at the header length, even inside the header.
            if (pos >= PW'(header_length_in)) begin
               if (!holding_left_in) begin
                  held_left_in    = in_byte_ff;
                  holding_left_in = 1'b1;
               end else begin
                  holding_left_in = 1'b0;
                  if (pixel_count_ff < IW'(uvc_sfa_pkg::FRAME_PIXELS)) begin
                     write_valid           = 1'b1;
                     write_res.result_kind = uvc_sfa_pkg::KIND_PIXEL_WRITE;
                     write_res.pixel_index = pixel_count_ff;
                     write_res.left_pixel  = held_left_in;
                     write_res.right_pixel = in_byte_ff;
                     write_res.frame_time  = frame_time_in;
                     pixel_count_in        = pixel_count_ff + 1'b1;
                  end
               end
            end
            byte_position_in = pos + 1'b1;
         end

         if (in_last_ff) begin
            if (frame_time_in == '0) begin
               frame_time_in = packet_time_in;
            end
            if (header_flags_in[uvc_sfa_pkg::EOF_FLAG_BIT]) begin
               frame_valid           = 1'b1;
               frame_res.result_kind =
                  (pixel_count_in == IW'(uvc_sfa_pkg::FRAME_PIXELS)) ?
                  uvc_sfa_pkg::KIND_FRAME_GOOD : uvc_sfa_pkg::KIND_FRAME_DROP;
               frame_res.pixel_index = pixel_count_in;
               frame_res.frame_time  = frame_time_in;
               pixel_count_in        = '0;
               frame_time_in         = '0;
            end else begin
               frame_time_in = packet_time_in;
            end
            holding_left_in  = 1'b0;
            held_left_in     = '0;
            byte_position_in = '0;
         end
      end

      push.count  = {1'b0, write_valid} + {1'b0, frame_valid};
      push.slot_a = write_valid ? write_res : frame_res;
      push.slot_b = frame_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         byte_position_ff <= '0;
         header_length_ff <= '0;
         header_flags_ff  <= '0;
         packet_time_ff   <= '0;
         frame_time_ff    <= '0;
         pixel_count_ff   <= '0;
         held_left_ff     <= '0;
         holding_left_ff  <= 1'b0;
      end else begin
         in_valid_ff      <= in_valid_in;
         byte_position_ff <= byte_position_in;
         header_length_ff <= header_length_in;
         header_flags_ff  <= header_flags_in;
         packet_time_ff   <= packet_time_in;
         frame_time_ff    <= frame_time_in;
         pixel_count_ff   <= pixel_count_in;
         held_left_ff     <= held_left_in;
         holding_left_ff  <= holding_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_byte_ff  <= req_if.payload_byte;
         in_first_ff <= req_if.first_of_packet;
         in_last_ff  <= req_if.last_of_packet;
      end
   end

`ifndef SYNTH
   a_last_restarts_packet: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_last_ff |=> byte_position_ff == '0 && !holding_left_ff)
      else $error("packet end did not restart the byte position");

   a_pixel_count_bounded: assert property (@(posedge clock) disable iff (reset)
      pixel_count_ff <= IW'(uvc_sfa_pkg::FRAME_PIXELS))
      else $error("pixel count ran past the frame size");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      frame_valid |=> pixel_count_ff == '0 && frame_time_ff == '0)
      else $error("frame result did not clear the count and frame time");
`endif

endmodule

### rtl/uvc_sfa_result_queue.sv
// ----------------------------------------------------------------------------
// Stereo frame assembler result queue
// Small register queue taking up to two results a cycle and presenting one
// result a cycle on the response channel while the receiver is ready.
// ----------------------------------------------------------------------------
module uvc_sfa_result_queue #(
   parameter int unsigned DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  uvc_sfa_pkg::push_type    push,
   output logic                     room,
   uvc_sfa_rsp_if.source            rsp_if
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   uvc_sfa_pkg::result_type entries [DEPTH];

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] tail_next1;
   logic [IDX_W-1:0] tail_next2;
   logic             pop;

   assign pop        = rsp_if.valid && rsp_if.ready;
   assign tail_next1 = (tail_ff == IDX_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign tail_next2 = (tail_next1 == IDX_W'(DEPTH - 1)) ? '0 : tail_next1 + 1'b1;

   // One request may be in the parser's input register and one more may be
   // accepted now, each producing up to two results.
   assign room = count_ff <= CNT_W'(DEPTH - 4);

   always_comb begin
      head_in = head_ff;
      if (pop) begin
         head_in = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      unique case (push.count)
         2'd1:    tail_in = tail_next1;
         2'd2:    tail_in = tail_next2;
         default: tail_in = tail_ff;
      endcase
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries[tail_ff] <= push.slot_a;
      end
      if (push.count == 2'd2) begin
         entries[tail_next1] <= push.slot_b;
      end
   end

   assign rsp_if.valid       = count_ff != '0;
   assign rsp_if.result_kind = entries[head_ff].result_kind;
   assign rsp_if.pixel_index = entries[head_ff].pixel_index;
   assign rsp_if.left_pixel  = entries[head_ff].left_pixel;
   assign rsp_if.right_pixel = entries[head_ff].right_pixel;
   assign rsp_if.frame_time  = entries[head_ff].frame_time;

`ifndef SYNTH
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue count exceeds its depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (CNT_W + 1)'(count_ff) + (CNT_W + 1)'(push.count) <=
      (CNT_W + 1)'(DEPTH) + (CNT_W + 1)'(pop))
      else $error("result queue written while full");

   a_empty_pointers_meet: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> head_ff == tail_ff)
      else $error("empty result queue with pointers apart");
`endif

endmodule

### rtl/uvc_stereo_frame_assembler.sv
// ----------------------------------------------------------------------------
// Stereo USB video frame assembler
// Turns payload packet bytes into left/right pixel pair writes and frame
// completion results.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one payload byte per request with first/last packet
//   markers. Byte 0 is the header length, byte 1 the flags, bytes 2 to 5 a
//   little-endian presentation time; bytes from the header length on
//   alternate left and right. rsp_if carries pixel pair writes at a running
//   frame index, and on the last byte of an end-of-frame packet a
//   frame-good or frame-dropped result with the number of pairs received.
//   A request is taken every cycle while the queue has room. Its results
//   reach rsp_if by way of the input register and the result queue: the
//   parse step reads the byte from the input register and writes its
//   results into a result queue of QUEUE_DEPTH entries, from which they are taken.
//   A byte that both completes a pair and ends a frame yields two results,
//   which leave the queue in order, pixel write first.
//   When the receiver stalls, the queue fills and req_if.ready drops once
//   fewer than four entries are free; nothing is lost.
//   Synchronous reset empties the queue and clears all packet and frame
//   state; the block is ready on the first cycle after reset.
// ----------------------------------------------------------------------------
module uvc_stereo_frame_assembler #(
   parameter int unsigned QUEUE_DEPTH = 8
) (
   input  logic           clock,
   input  logic           reset,
   uvc_sfa_req_if.sink    req_if,
   uvc_sfa_rsp_if.source  rsp_if
);

   uvc_sfa_pkg::push_type push;
   logic                  room;

   uvc_sfa_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .room   (room),
      .push   (push)
   );

   uvc_sfa_result_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_result_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .room   (room),
      .rsp_if (rsp_if)
   );

endmodule

### dv/tb_uvc_stereo_frame_assembler.sv
// ----------------------------------------------------------------------------
// Stereo frame assembler testbench
// Drives payload packets into the assembler and checks every pixel pair write
// and frame result against a cycle-free model of the packet and frame state.
// Directed packets and random packet streams are run, the random streams under
// several patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_uvc_stereo_frame_assembler;

   localparam int unsigned CLOCK_PERIOD = 20;
   localparam int unsigned LIMIT_CYCLES = 2000000;
   localparam int unsigned DRAIN_CYCLES = 16;

   logic clock;
   logic reset;

   uvc_sfa_req_if req_if ();
   uvc_sfa_rsp_if rsp_if ();

   uvc_stereo_frame_assembler i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   // Model of the packet parser and frame state
   logic [uvc_sfa_pkg::POS_W-1:0]   byte_pos;
   logic [uvc_sfa_pkg::BYTE_W-1:0]  hdr_length;
   logic [uvc_sfa_pkg::BYTE_W-1:0]  hdr_flags;
   logic [uvc_sfa_pkg::TIME_W-1:0]  pkt_stamp;
   logic [uvc_sfa_pkg::TIME_W-1:0]  frame_stamp;
   logic [uvc_sfa_pkg::INDEX_W-1:0] pair_count;
   logic [uvc_sfa_pkg::BYTE_W-1:0]  left_byte;
   bit                              have_left;

   uvc_sfa_pkg::result_type awaited_results[$];
   uvc_sfa_pkg::result_type oldest;
   int unsigned mismatch_count;
   int unsigned sent_requests;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   bit          packet_closed;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLOCK_PERIOD * LIMIT_CYCLES);
      $display("tb_uvc_stereo_frame_assembler NOT OK");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic void assemble_byte(input logic [uvc_sfa_pkg::BYTE_W-1:0] value,
                                         input bit first_mark, input bit last_mark);
      logic [uvc_sfa_pkg::POS_W-1:0] pos;
      uvc_sfa_pkg::result_type       res;
      if (first_mark)
         byte_pos = '0;
      pos = byte_pos;
      if (pos < uvc_sfa_pkg::MAX_PACKET_BYTES) begin
         if (pos == uvc_sfa_pkg::POS_HEADER_LENGTH) begin
            hdr_length = value;
            hdr_flags  = '0;
            pkt_stamp  = '0;
            have_left  = 1'b0;
            left_byte  = '0;
         end else if (pos == uvc_sfa_pkg::POS_HEADER_FLAGS) begin
            hdr_flags = value;
         end else if (pos >= uvc_sfa_pkg::POS_TIME_FIRST &&
                      pos <= uvc_sfa_pkg::POS_TIME_LAST) begin
            pkt_stamp |= uvc_sfa_pkg::TIME_W'(value) <<
                         (8 * (pos - uvc_sfa_pkg::POS_TIME_FIRST));
            if (pos == uvc_sfa_pkg::POS_TIME_LAST && frame_stamp == '0)
               frame_stamp = pkt_stamp;
         end
         // Pixel bytes start at the header length, even inside the header.
         if (pos >= uvc_sfa_pkg::POS_W'(hdr_length)) begin
            if (!have_left) begin
               left_byte = value;
               have_left = 1'b1;
            end else begin
               have_left = 1'b0;
               if (pair_count < uvc_sfa_pkg::FRAME_PIXELS) begin
                  res.result_kind = uvc_sfa_pkg::KIND_PIXEL_WRITE;
                  res.pixel_index = pair_count;
                  res.left_pixel  = left_byte;
                  res.right_pixel = value;
                  res.frame_time  = frame_stamp;
                  awaited_results.push_back(res);
                  pair_count++;
               end
            end
         end
         byte_pos = pos + 1'b1;
      end
      if (last_mark) begin
         if (frame_stamp == '0)
            frame_stamp = pkt_stamp;
         if (hdr_flags[uvc_sfa_pkg::EOF_FLAG_BIT]) begin
            res.result_kind = (pair_count == uvc_sfa_pkg::FRAME_PIXELS) ?
                              uvc_sfa_pkg::KIND_FRAME_GOOD :
                              uvc_sfa_pkg::KIND_FRAME_DROP;
            res.pixel_index = pair_count;
            res.left_pixel  = '0;
            res.right_pixel = '0;
            res.frame_time  = frame_stamp;
            awaited_results.push_back(res);
            pair_count  = '0;
            frame_stamp = '0;
         end else begin
            frame_stamp = pkt_stamp;
         end
         have_left = 1'b0;
         left_byte = '0;
         byte_pos  = '0;
      end
   endfunction

   // Entered and left at a falling edge; valid stays high between back-to-back requests.
   task automatic push_byte(input logic [uvc_sfa_pkg::BYTE_W-1:0] value,
                            input bit first_mark, input bit last_mark);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.payload_byte    <= value;
      req_if.first_of_packet <= first_mark;
      req_if.last_of_packet  <= last_mark;
      do @(posedge clock); while (!req_if.ready);
      assemble_byte(value, first_mark, last_mark);
      sent_requests++;
      packet_closed = last_mark;
      @(negedge clock);
   endtask

   task automatic push_packet(input logic [uvc_sfa_pkg::BYTE_W-1:0] bytes[$],
                              input bit first_mark);
      foreach (bytes[i])
         push_byte(bytes[i], first_mark && i == 0, i == bytes.size() - 1);
   endtask

   always @(negedge clock)
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d index %0d",
                                      rsp_if.result_kind, rsp_if.pixel_index));
         end else begin
            oldest = awaited_results.pop_front();
            if (rsp_if.result_kind !== oldest.result_kind)
               report_mismatch($sformatf("result_kind %0d, expected %0d",
                                         rsp_if.result_kind, oldest.result_kind));
            if (rsp_if.pixel_index !== oldest.pixel_index)
               report_mismatch($sformatf("pixel_index %0d, expected %0d",
                                         rsp_if.pixel_index, oldest.pixel_index));
            if (rsp_if.left_pixel !== oldest.left_pixel)
               report_mismatch($sformatf("left_pixel %h, expected %h at index %0d",
                                         rsp_if.left_pixel, oldest.left_pixel,
                                         oldest.pixel_index));
            if (rsp_if.right_pixel !== oldest.right_pixel)
               report_mismatch($sformatf("right_pixel %h, expected %h at index %0d",
                                         rsp_if.right_pixel, oldest.right_pixel,
                                         oldest.pixel_index));
            if (rsp_if.frame_time !== oldest.frame_time)
               report_mismatch($sformatf("frame_time %h, expected %h at index %0d",
                                         rsp_if.frame_time, oldest.frame_time,
                                         oldest.pixel_index));
         end
      end
   end

   // Header edge cases, short packets, unpaired bytes and an implied packet start.
   task automatic test_directed_packets;
      push_packet('{8'hFF}, 1'b1);
      push_packet('{8'h00, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55}, 1'b1);
      push_packet('{8'h06, 8'h02, 8'h78, 8'h56, 8'h34, 8'h12, 8'hFF, 8'h00}, 1'b1);
      push_packet('{8'h0C, 8'h02, 8'hAA}, 1'b1);
      push_packet('{8'h03, 8'h00, 8'h80, 8'h01, 8'h02, 8'h03, 8'h04}, 1'b0);
   endtask

   // Well-formed packets with random content, mixed with broken byte runs.
   task automatic test_random_packets(input int unsigned request_target);
      int unsigned                    len;
      int unsigned                    hlen;
      logic [uvc_sfa_pkg::BYTE_W-1:0] flags;
      logic [uvc_sfa_pkg::TIME_W-1:0] stamp;
      logic [uvc_sfa_pkg::BYTE_W-1:0] value;
      bit                             first_mark;
      request_target += sent_requests;
      while (sent_requests < request_target) begin
         if ($urandom_range(9) < 8) begin
            len  = ($urandom_range(19) == 0) ? $urandom_range(1, 6) : $urandom_range(6, 28);
            hlen = ($urandom_range(3) == 0) ? $urandom_range(0, 6) : $urandom_range(6, 12);
            if ($urandom_range(29) == 0)
               hlen = 255;
            flags = uvc_sfa_pkg::BYTE_W'($urandom);
            flags[uvc_sfa_pkg::EOF_FLAG_BIT] = ($urandom_range(2) == 0);
            stamp = ($urandom_range(4) == 0) ? '0 : $urandom;
            // A packet may rely on the previous last marker for its start.
            first_mark = !packet_closed || $urandom_range(7) != 0;
            for (int unsigned i = 0; i < len; i++) begin
               if (i == 0)
                  value = uvc_sfa_pkg::BYTE_W'(hlen);
               else if (i == 1)
                  value = flags;
               else if (i <= 5)
                  value = stamp[8*(i-2) +: 8];
               else
                  value = uvc_sfa_pkg::BYTE_W'($urandom);
               push_byte(value, first_mark && i == 0, i == len - 1);
            end
         end else begin
            len = $urandom_range(1, 8);
            for (int unsigned i = 0; i < len; i++)
               push_byte(uvc_sfa_pkg::BYTE_W'($urandom), $urandom_range(5) == 0,
                         $urandom_range(5) == 0);
         end
      end
   endtask

   initial begin
      reset                  = 1'b1;
      req_if.valid           = 1'b0;
      req_if.payload_byte    = '0;
      req_if.first_of_packet = 1'b0;
      req_if.last_of_packet  = 1'b0;
      rsp_if.ready           = 1'b0;
      byte_pos               = '0;
      hdr_length             = '0;
      hdr_flags              = '0;
      pkt_stamp              = '0;
      frame_stamp            = '0;
      pair_count             = '0;
      left_byte              = '0;
      have_left              = 1'b0;
      mismatch_count         = 0;
      sent_requests          = 0;
      packet_closed          = 1'b1;
      send_idle_pct          = 30;
      recv_idle_pct          = 73;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_packets();
      test_random_packets(200);
      send_idle_pct = 73;
      recv_idle_pct = 30;
      test_random_packets(200);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_packets(200);
      req_if.valid <= 1'b0;

      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_uvc_stereo_frame_assembler OK");
      else
         $display("tb_uvc_stereo_frame_assembler NOT OK");
      $finish;
   end

endmodule

### uvc_stereo_frame_assembler.f
rtl/uvc_sfa_pkg.sv
rtl/uvc_sfa_if.sv
rtl/uvc_sfa_parser.sv
rtl/uvc_sfa_result_queue.sv
rtl/uvc_stereo_frame_assembler.sv
dv/tb_uvc_stereo_frame_assembler.sv
